// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define SST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted set table check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define SST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted set table check failed");

`endif

// ===== hw/rtl/sst_pkg.sv =====
`timescale 1ns / 1ps

package sst_pkg;

  localparam int FUNC_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_SEARCH = 3'd2,
    FUNC_CLEAR  = 3'd3,
    FUNC_FIRST  = 3'd4,
    FUNC_NEXT   = 3'd5
  } func_e;

endpackage

// ===== hw/rtl/sorted_set_table.sv =====
// operation: search/insert/remove scan the entries below the value, insert/remove then
// shift each moved entry one slot; clear, unknown codes and misses of first/next go
// straight to the result, first/next hits read one entry; then the output reg holds it
// throughput: one beat in flight; the next beat is taken once the result reaches the
// output reg, paced by the one read port of the entry store and one comparator
// reset: rst_ni clears count, walk cursor and handshake state; entry store is not cleared
`timescale 1ns / 1ps

module sorted_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sst_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [sst_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [sst_pkg::DATA_W-1:0] item_value_o
);
  import sst_pkg::*;

  // address width of the store, and count width that can also hold CAPACITY itself
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,  // issue read of the entry under idx
    S_CMP     = 7'b0000100,  // compare the read entry with the operand
    S_MOVE_RD = 7'b0001000,  // read the neighbor to shift
    S_MOVE_WR = 7'b0010000,  // write it one slot over
    S_FETCH   = 7'b0100000,  // walk read returns
    S_DONE    = 7'b1000000   // hand the result to the output register
  } state_e;

  state_e                   state_q, state_d;
  logic [FUNC_W-1:0]        op_q, op_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic [CW-1:0]            count_q, count_d;   // number of stored entries
  logic [CW-1:0]            wpos_q, wpos_d;     // walk cursor: index next will give
  logic                     wact_q, wact_d;     // walk started by first
  logic [CW-1:0]            idx_q, idx_d;       // scan index, later the sorted position
  logic [CW-1:0]            j_q, j_d;           // shift index
  logic                     res_ok_q, res_ok_d;
  logic signed [DATA_W-1:0] res_item_q, res_item_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_ok_q, out_ok_d;
  logic signed [DATA_W-1:0] out_item_q, out_item_d;

  // store port
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  // the one shared comparator: stored entry against the operand
  logic cmp_lt, cmp_eq;
  assign cmp_lt = mem_rdata < value_q;
  assign cmp_eq = mem_rdata == value_q;

  logic [CW-1:0] j_dec, j_inc;
  assign j_dec = j_q - CW'(1);
  assign j_inc = j_q + CW'(1);

  // scan end: idx_q holds the lower bound, hit tells whether the value sits there
  logic decide, hit;

  sst_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    value_d     = value_q;
    count_d     = count_q;
    wpos_d      = wpos_q;
    wact_d      = wact_q;
    idx_d       = idx_q;
    j_d         = j_q;
    res_ok_d    = res_ok_q;
    res_item_d  = res_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ok_d    = out_ok_q;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = j_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_q[AW-1:0];
    decide      = 1'b0;
    hit         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = func_i;
          value_d    = value_i;
          res_ok_d   = 1'b0;
          res_item_d = '0;
          idx_d      = '0;
          state_d    = S_DONE;
          case (func_i)
            FUNC_INSERT, FUNC_REMOVE, FUNC_SEARCH: begin
              state_d = S_SCAN;
            end
            FUNC_CLEAR: begin
              count_d  = '0;
              wpos_d   = '0;
              wact_d   = 1'b0;
              res_ok_d = 1'b1;
            end
            FUNC_FIRST: begin
              if (count_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                wpos_d    = CW'(1);
                wact_d    = 1'b1;
                state_d   = S_FETCH;
              end else begin
                wpos_d = '0;
                wact_d = 1'b0;
              end
            end
            FUNC_NEXT: begin
              if (wact_q && (wpos_q < count_q)) begin
                mem_re    = 1'b1;
                mem_raddr = wpos_q[AW-1:0];
                wpos_d    = wpos_q + CW'(1);
                state_d   = S_FETCH;
              end
            end
            default: begin
              // unknown operation: ok stays low, nothing changes
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_q == count_q) begin
          decide = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          state_d   = S_CMP;
        end
      end

      S_CMP: begin
        if (cmp_lt) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_SCAN;
        end else begin
          decide = 1'b1;
          hit    = cmp_eq;
        end
      end

      S_MOVE_RD: begin
        if (op_q == FUNC_INSERT) begin
          if (j_q == idx_q) begin
            // gap has reached the sorted position
            mem_we    = 1'b1;
            mem_waddr = idx_q[AW-1:0];
            mem_wdata = value_q;
            state_d   = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = j_dec[AW-1:0];
            state_d   = S_MOVE_WR;
          end
        end else begin
          if (j_inc >= count_q) begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = j_inc[AW-1:0];
            state_d   = S_MOVE_WR;
          end
        end
      end

      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[AW-1:0];
        mem_wdata = mem_rdata;
        j_d       = (op_q == FUNC_INSERT) ? j_dec : j_inc;
        state_d   = S_MOVE_RD;
      end

      S_FETCH: begin
        res_ok_d   = 1'b1;
        res_item_d = mem_rdata;
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_item_d  = res_item_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // end of scan: act on the lower bound
    if (decide) begin
      state_d = S_DONE;
      case (op_q)
        FUNC_SEARCH: begin
          res_ok_d = hit;
        end
        FUNC_INSERT: begin
          if (hit) begin
            res_ok_d = 1'b1;
          end else if (count_q != CW'(CAPACITY)) begin
            // open a gap at idx by shifting the tail up, top entry first
            res_ok_d = 1'b1;
            j_d      = count_q;
            count_d  = count_q + CW'(1);
            if (wact_q && (idx_q <= wpos_q)) begin
              wpos_d = wpos_q + CW'(1);
            end
            state_d = S_MOVE_RD;
          end
        end
        FUNC_REMOVE: begin
          if (hit) begin
            // close the gap by shifting the tail down
            res_ok_d = 1'b1;
            j_d      = idx_q;
            if (wact_q && (idx_q < wpos_q)) begin
              wpos_d = wpos_q - CW'(1);
            end
            state_d = S_MOVE_RD;
          end
        end
        default: begin
          res_ok_d = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wpos_q      <= '0;
      wact_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wpos_q      <= wpos_d;
      wact_q      <= wact_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    value_q    <= value_d;
    idx_q      <= idx_d;
    j_q        <= j_d;
    res_ok_q   <= res_ok_d;
    res_item_q <= res_item_d;
    out_ok_q   <= out_ok_d;
    out_item_q <= out_item_d;
  end

  // one beat in flight: busy from accept until the result moves to the output register
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign item_value_o = out_item_q;

endmodule

// ===== hw/rtl/sst_store.sv =====
`timescale 1ns / 1ps

// entry store: one write port, one read port, registered read data
module sst_store #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic signed [sst_pkg::DATA_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic signed [sst_pkg::DATA_W-1:0] rdata_o
);
  import sst_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sst_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sst_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              ok_o,
  input logic signed [sst_pkg::DATA_W-1:0] item_value_o
);
  import sst_pkg::*;

  // a stalled result beat stays
  `SST_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // a stalled result beat keeps its payload
  `SST_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(ok_o) && $stable(item_value_o))
  // a failed result never carries a value
  `SST_ASSERT_IMP(a_fail_zero, out_valid_o && !ok_o, item_value_o == '0)
  // an accepted beat keeps the block busy in the next cycle
  `SST_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind sorted_set_table sst_checker u_sst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ok_o         (ok_o),
  .item_value_o (item_value_o)
);
